/* sv/scancode_decoder_event_stack_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef SCANCODE_DECODER_EVENT_STACK_CORE_DEFINES_SVH
`define SCANCODE_DECODER_EVENT_STACK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define SCDES_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scancode decoder check failed");

// Next-cycle implication, disabled while reset is low
`define SCDES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scancode decoder check failed");

`endif

/* sv/scdes_pkg.sv */
`default_nettype none

package scdes_pkg;

    // Default number of stacked events
    localparam int STACK_DEPTH_DEF = 256;

    // Request kinds
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    // Scancode constants
    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [6:0] KC_LSHIFT   = 7'h2A;
    localparam logic [6:0] KC_RSHIFT   = 7'h36;
    localparam logic [6:0] KC_CTRL     = 7'h1D;
    localparam logic [6:0] KC_ALT      = 7'h38;
    localparam logic [6:0] KC_DELETE   = 7'h53;
    localparam logic [6:0] CHAR_LIMIT  = 7'd78;

    // One stacked event, low bits first: key code, release, char, modifiers
    typedef struct packed {
        logic       alt;
        logic       ctrl;
        logic       shift;
        logic [6:0] character;
        logic       released;
        logic [6:0] key_code;
    } t_event;

    localparam int EVENT_W = $bits(t_event);

    // ASCII lookup; pair holds {plain, shifted}
    function automatic logic [6:0] char_lookup(input logic [6:0] kc, input logic shifted);
        logic [13:0] pair;
        pair = '0;
        if (kc < CHAR_LIMIT) begin
            case (kc)
                7'd2:    pair = {7'h31, 7'h21};
                7'd3:    pair = {7'h32, 7'h40};
                7'd4:    pair = {7'h33, 7'h23};
                7'd5:    pair = {7'h34, 7'h24};
                7'd6:    pair = {7'h35, 7'h25};
                7'd7:    pair = {7'h36, 7'h5E};
                7'd8:    pair = {7'h37, 7'h26};
                7'd9:    pair = {7'h38, 7'h2A};
                7'd10:   pair = {7'h39, 7'h28};
                7'd11:   pair = {7'h30, 7'h29};
                7'd12:   pair = {7'h2D, 7'h5F};
                7'd13:   pair = {7'h3D, 7'h2B};
                7'd14:   pair = {7'h08, 7'h08};
                7'd15:   pair = {7'h09, 7'h09};
                7'd16:   pair = {7'h71, 7'h51};
                7'd17:   pair = {7'h77, 7'h57};
                7'd18:   pair = {7'h65, 7'h45};
                7'd19:   pair = {7'h72, 7'h52};
                7'd20:   pair = {7'h74, 7'h54};
                7'd21:   pair = {7'h79, 7'h59};
                7'd22:   pair = {7'h75, 7'h55};
                7'd23:   pair = {7'h69, 7'h49};
                7'd24:   pair = {7'h6F, 7'h4F};
                7'd25:   pair = {7'h70, 7'h50};
                7'd26:   pair = {7'h5B, 7'h7B};
                7'd27:   pair = {7'h5D, 7'h7D};
                7'd28:   pair = {7'h0A, 7'h0A};
                7'd30:   pair = {7'h61, 7'h41};
                7'd31:   pair = {7'h73, 7'h53};
                7'd32:   pair = {7'h64, 7'h44};
                7'd33:   pair = {7'h66, 7'h46};
                7'd34:   pair = {7'h67, 7'h47};
                7'd35:   pair = {7'h68, 7'h48};
                7'd36:   pair = {7'h6A, 7'h4A};
                7'd37:   pair = {7'h6B, 7'h4B};
                7'd38:   pair = {7'h6C, 7'h4C};
                7'd39:   pair = {7'h3B, 7'h3A};
                7'd40:   pair = {7'h27, 7'h22};
                7'd41:   pair = {7'h60, 7'h7E};
                7'd43:   pair = {7'h5C, 7'h7C};
                7'd44:   pair = {7'h7A, 7'h5A};
                7'd45:   pair = {7'h78, 7'h58};
                7'd46:   pair = {7'h63, 7'h43};
                7'd47:   pair = {7'h76, 7'h56};
                7'd48:   pair = {7'h62, 7'h42};
                7'd49:   pair = {7'h6E, 7'h4E};
                7'd50:   pair = {7'h6D, 7'h4D};
                7'd51:   pair = {7'h2C, 7'h3C};
                7'd52:   pair = {7'h2E, 7'h3E};
                7'd53:   pair = {7'h2F, 7'h3F};
                7'd55:   pair = {7'h2A, 7'h2A};
                7'd57:   pair = {7'h20, 7'h20};
                7'd74:   pair = {7'h2D, 7'h2D};
                default: pair = '0;
            endcase
        end
        return shifted ? pair[6:0] : pair[13:7];
    endfunction

endpackage

`default_nettype wire

/* sv/scdes_ram.sv */
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module scdes_ram
    import scdes_pkg::*;
#(
    parameter int WIDTH = EVENT_W,
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/scancode_decoder_event_stack_core.sv */
// Set-1 scancode decoder with a LIFO event stack. Each transfer on the input
// channel is either a scancode byte or a poll, and each produces exactly one
// result transfer. One item is accepted per clock unless the input stalls as
// described below. A result is presented from the output register: the stack
// RAM read and the output register are the two register stages between an
// item's transfer and its result. While a result waits at the output, one
// more item is accepted into the RAM read stage; the input then stalls until
// the waiting result is taken. Modifier state, the extended-prefix flag
// and the event count update at the accepting edge, so back-to-back pushes
// and pops see each other. The stack RAM needs no clearing pass after reset:
// entries are only read after being pushed.
`default_nettype none

module scancode_decoder_event_stack_core
    import scdes_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_scan_byte,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_event_valid,
    output logic      [6:0] o_key_code,
    output logic            o_released,
    output logic      [6:0] o_character,
    output logic            o_shift_held,
    output logic            o_ctrl_held,
    output logic            o_alt_held,
    output logic            o_reboot_request,
    output logic            o_events_available
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);

    // Decoder state
    logic [CW-1:0] r_count, n_count;
    logic          r_shift, n_shift;
    logic          r_ctrl, n_ctrl;
    logic          r_alt, n_alt;
    logic          r_prefix, n_prefix;

    // Stage 1: waiting on the RAM read
    logic r_s1_valid, r_s1_pop, r_s1_reboot, r_s1_avail;

    // Output register
    logic   r_out_valid, r_out_evalid, r_out_reboot, r_out_avail;
    t_event r_out_event;

    // Handshake and pipeline advance
    logic s2_free, s1_adv, in_xfer;
    assign s2_free    = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_ready = !r_s1_valid || s2_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Decode of the incoming item
    logic          is_poll, pop_ok, prefix_start, key_byte, is_mod, push, reboot;
    logic [6:0]    kc;
    logic          rel;
    logic [CW-1:0] cnt_dec;
    t_event        wr_event;
    logic [EVENT_W-1:0] rd_data;

    assign kc      = i_scan_byte[6:0];
    assign rel     = i_scan_byte[7];
    assign cnt_dec = r_count - 1'b1;

    always_comb begin
        is_poll      = (i_req_type == REQ_POLL);
        pop_ok       = is_poll && (r_count != '0);
        prefix_start = !is_poll && (i_scan_byte == PREFIX_BYTE) && !r_prefix;
        key_byte     = !is_poll && !prefix_start;
        is_mod       = (kc == KC_LSHIFT) || (kc == KC_RSHIFT) ||
                       (kc == KC_CTRL) || (kc == KC_ALT);
        push         = key_byte && !is_mod && (r_count < COUNT_FULL);
        reboot       = push && (kc == KC_DELETE) && r_prefix && r_ctrl && r_alt;

        wr_event.alt       = r_alt;
        wr_event.ctrl      = r_ctrl;
        wr_event.shift     = r_shift;
        wr_event.character = char_lookup(kc, r_shift);
        wr_event.released  = rel;
        wr_event.key_code  = kc;

        n_count  = r_count;
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_alt    = r_alt;
        n_prefix = r_prefix;
        if (in_xfer) begin
            if (prefix_start) begin
                n_prefix = 1'b1;
            end else if (key_byte) begin
                n_prefix = 1'b0;
                if ((kc == KC_LSHIFT) || (kc == KC_RSHIFT)) begin
                    n_shift = !rel;
                end
                if (kc == KC_CTRL) begin
                    n_ctrl = !rel;
                end
                if (kc == KC_ALT) begin
                    n_alt = !rel;
                end
            end
            if (push) begin
                n_count = r_count + 1'b1;
            end else if (pop_ok) begin
                n_count = cnt_dec;
            end
        end
    end

    // Event stack
    scdes_ram #(
        .WIDTH(EVENT_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (in_xfer && push),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(wr_event),
        .i_re   (in_xfer && pop_ok),
        .i_raddr(cnt_dec[AW-1:0]),
        .o_rdata(rd_data)
    );

    // Decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
            r_alt    <= 1'b0;
            r_prefix <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
            r_alt    <= n_alt;
            r_prefix <= n_prefix;
        end
    end

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_pop    <= pop_ok;
            r_s1_reboot <= reboot;
            r_s1_avail  <= (n_count != '0);
        end
    end

    // Output register; event fields read as zero without a popped event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_evalid <= r_s1_pop;
            r_out_event  <= r_s1_pop ? t_event'(rd_data) : '0;
            r_out_reboot <= r_s1_reboot;
            r_out_avail  <= r_s1_avail;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_valid      = r_out_evalid;
    assign o_key_code         = r_out_event.key_code;
    assign o_released         = r_out_event.released;
    assign o_character        = r_out_event.character;
    assign o_shift_held       = r_out_event.shift;
    assign o_ctrl_held        = r_out_event.ctrl;
    assign o_alt_held         = r_out_event.alt;
    assign o_reboot_request   = r_out_reboot;
    assign o_events_available = r_out_avail;

endmodule

`default_nettype wire

/* sv/scdes_checker.sv */
`default_nettype none

`include "scancode_decoder_event_stack_core_defines.svh"

// Port-level checks on the result channel
module scdes_checker
    import scdes_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_event_valid,
    input wire logic [6:0] o_key_code,
    input wire logic       o_released,
    input wire logic [6:0] o_character,
    input wire logic       o_shift_held,
    input wire logic       o_ctrl_held,
    input wire logic       o_alt_held,
    input wire logic       o_reboot_request,
    input wire logic       o_events_available
);

    logic [17:0] event_bits;
    logic [20:0] out_bits;
    assign event_bits = {o_alt_held, o_ctrl_held, o_shift_held, o_character,
                         o_released, o_key_code};
    assign out_bits   = {o_event_valid, event_bits, o_reboot_request, o_events_available};

    // A stalled result holds
    `SCDES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(out_bits))

    // No popped event means all event fields are zero
    `SCDES_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_event_valid, event_bits == 18'd0)

    // A reboot pulse comes from a stored scancode, never from a poll
    `SCDES_ASSERT_NOW(a_reboot_src, i_clk, i_rst_n, o_out_valid && o_reboot_request, !o_event_valid && o_events_available)

    // Characters exist only for low key codes
    `SCDES_ASSERT_NOW(a_char_range, i_clk, i_rst_n, o_out_valid && (o_character != 7'd0), o_key_code < CHAR_LIMIT)

    // Input stalls only behind a result that is waiting
    `SCDES_ASSERT_NOW(a_in_stall, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

endmodule

bind scancode_decoder_event_stack_core scdes_checker u_scdes_checker (.*);

`default_nettype wire
